[hdl/csf_pkg.sv]
`timescale 1ns / 1ps
package csf_pkg;

  // Most sizes sent for one graph
  localparam int unsigned RESULT_LIMIT = 45;
  localparam int unsigned RES_CNT_W    = 6;

  typedef struct packed {
    logic [9:0] end_a;
    logic [9:0] end_b;
    logic       final_edge;
  } csf_in_t;

  typedef struct packed {
    logic [10:0] comp_size;
    logic        last_size;
    logic        edges_dropped;
  } csf_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINK_A,
    ST_LINK_B,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_POP,
    ST_HEAD,
    ST_LINK,
    ST_NBR,
    ST_VIS,
    ST_SIZE_RD,
    ST_SIZE_CHK,
    ST_FLUSH
  } csf_state_e;

  typedef struct packed {
    logic load;
    logic link_a;
    logic link_b;
    logic scan_rd;
    logic comp_start;
    logic scan_next;
    logic pop;
    logic head_rd;
    logic link_ld;
    logic nbr_take;
    logic vis_chk;
    logic size_rd;
    logic size_take;
    logic flush;
    logic clr_step;
  } csf_cmd_t;

  typedef struct packed {
    logic in_ok;
    logic in_fin;
    logic fin_q;
    logic start_ok;
    logic scan_last;
    logic stack_empty;
    logic head_nil;
    logic s_nil;
    logic size_stall;
    logic out_free;
    logic clr_last;
    logic pend_v;
  } csf_stat_t;

endpackage

[hdl/csf_ctrl.sv]
`timescale 1ns / 1ps
module csf_ctrl
  import csf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  csf_stat_t stat_i,
  output csf_cmd_t  cmd_o
);

  csf_state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.in_ok) state_d = ST_LINK_A;
          else if (stat_i.in_fin) state_d = ST_SCAN;
        end
      end
      ST_LINK_A: state_d = ST_LINK_B;
      ST_LINK_B: state_d = stat_i.fin_q ? ST_SCAN : ST_IDLE;
      ST_SCAN:   state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (stat_i.start_ok) state_d = ST_POP;
        else if (stat_i.scan_last) state_d = ST_FLUSH;
        else state_d = ST_SCAN;
      end
      ST_POP:  state_d = stat_i.stack_empty ? ST_SIZE_RD : ST_HEAD;
      ST_HEAD: state_d = ST_LINK;
      ST_LINK: state_d = stat_i.head_nil ? ST_POP : ST_NBR;
      ST_NBR:  state_d = ST_VIS;
      ST_VIS:  state_d = stat_i.s_nil ? ST_POP : ST_NBR;
      ST_SIZE_RD: state_d = ST_SIZE_CHK;
      ST_SIZE_CHK: begin
        if (!stat_i.size_stall) state_d = stat_i.scan_last ? ST_FLUSH : ST_SCAN;
      end
      ST_FLUSH: begin
        if (stat_i.out_free) state_d = ST_CLEAR;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_LINK_A: cmd_o.link_a = 1'b1;
      ST_LINK_B: cmd_o.link_b = 1'b1;
      ST_SCAN:   cmd_o.scan_rd = 1'b1;
      ST_SCAN_CHK: begin
        if (stat_i.start_ok) cmd_o.comp_start = 1'b1;
        else cmd_o.scan_next = 1'b1;
      end
      ST_POP:  cmd_o.pop = !stat_i.stack_empty;
      ST_HEAD: cmd_o.head_rd = 1'b1;
      ST_LINK: cmd_o.link_ld = 1'b1;
      ST_NBR:  cmd_o.nbr_take = 1'b1;
      ST_VIS:  cmd_o.vis_chk = 1'b1;
      ST_SIZE_RD: cmd_o.size_rd = 1'b1;
      ST_SIZE_CHK: begin
        if (!stat_i.size_stall) begin
          cmd_o.size_take = 1'b1;
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_FLUSH: cmd_o.flush = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

[hdl/csf_dp.sv]
`timescale 1ns / 1ps
module csf_dp
  import csf_pkg::*;
#(
  parameter int unsigned NODE_COUNT    = 1024,
  parameter int unsigned EDGE_CAPACITY = 2048
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  csf_in_t   in_data_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output csf_out_t  out_data_o,
  input  csf_cmd_t  cmd_i,
  output csf_stat_t stat_o
);

  localparam int unsigned SLOT_TOTAL = 2 * EDGE_CAPACITY;
  localparam int unsigned NW  = $clog2(NODE_COUNT);
  localparam int unsigned DW  = $clog2(NODE_COUNT + 1);
  localparam int unsigned SIW = $clog2(SLOT_TOTAL);
  localparam int unsigned LW  = $clog2(SLOT_TOTAL + 1);
  localparam logic [LW-1:0] NIL = LW'(SLOT_TOTAL);

  // Stores
  logic [LW-1:0] head_mem    [NODE_COUNT];
  logic [LW-1:0] next_mem    [SLOT_TOTAL];
  logic [NW-1:0] nbr_mem     [SLOT_TOTAL];
  logic          present_mem [NODE_COUNT];
  logic          visited_mem [NODE_COUNT];
  logic [NW-1:0] stack_mem   [NODE_COUNT];
  logic          rep_mem     [NODE_COUNT + 1];

  // Read data
  logic [LW-1:0] head_rd, next_rd;
  logic [NW-1:0] nbr_rd, stk_rd;
  logic          present_rd, visited_rd, rep_rd;

  // Control and working registers
  logic [LW-1:0]        slot_cnt_q;
  logic                 ovf_q;
  logic [NW-1:0]        n_q;
  logic [DW-1:0]        depth_q, count_q, clr_q, pend_q;
  logic                 pend_v_q;
  logic [RES_CNT_W-1:0] res_cnt_q;
  logic [LW-1:0]        s_q;
  logic [NW-1:0]        a_q, b_q, nb_q;
  logic                 fin_q;
  logic                 out_valid_q;
  csf_out_t             out_q;

  logic in_ok, out_free, size_new, take_ok, clr_node;

  // Port controls
  logic          head_we, head_re;
  logic [NW-1:0] head_wa, head_ra;
  logic [LW-1:0] head_wd;
  logic          slot_we, slot_re;
  logic [SIW-1:0] slot_wa, slot_ra;
  logic [LW-1:0] slot_next_wd;
  logic [NW-1:0] slot_nbr_wd;
  logic          pres_we;
  logic [NW-1:0] pres_wa;
  logic          pres_wd;
  logic          vis_we, vis_re;
  logic [NW-1:0] vis_wa, vis_ra;
  logic          vis_wd;
  logic          stk_we;
  logic [NW-1:0] stk_wa, stk_wd;
  logic          rep_we;
  logic [DW-1:0] rep_wa;
  logic          rep_wd;

  assign in_ok = (32'(in_data_i.end_a) < NODE_COUNT) && (32'(in_data_i.end_b) < NODE_COUNT)
              && (32'(slot_cnt_q) + 32'd2 <= SLOT_TOTAL);
  assign out_free = !out_valid_q || out_ready_i;
  assign size_new = (count_q > DW'(1)) && !rep_rd;
  assign take_ok  = 32'(res_cnt_q) < RESULT_LIMIT;
  assign clr_node = 32'(clr_q) < NODE_COUNT;

  // Status
  always_comb begin
    stat_o.in_ok       = in_ok;
    stat_o.in_fin      = in_data_i.final_edge;
    stat_o.fin_q       = fin_q;
    stat_o.start_ok    = present_rd && !visited_rd;
    stat_o.scan_last   = n_q == NW'(NODE_COUNT - 1);
    stat_o.stack_empty = depth_q == '0;
    stat_o.head_nil    = head_rd == NIL;
    stat_o.s_nil       = s_q == NIL;
    stat_o.size_stall  = size_new && take_ok && pend_v_q && !out_free;
    stat_o.out_free    = out_free;
    stat_o.clr_last    = clr_q == DW'(NODE_COUNT);
    stat_o.pend_v      = pend_v_q;
  end

  // Select list head port
  always_comb begin
    head_we = 1'b0;
    head_wa = a_q;
    head_wd = slot_cnt_q;
    head_re = cmd_i.load || cmd_i.link_a || cmd_i.head_rd;
    head_ra = stk_rd;
    if (cmd_i.load) head_ra = NW'(in_data_i.end_a);
    else if (cmd_i.link_a) head_ra = b_q;
    if (cmd_i.link_a) begin
      head_we = 1'b1;
    end else if (cmd_i.link_b) begin
      head_we = 1'b1;
      head_wa = b_q;
      head_wd = slot_cnt_q + LW'(1);
    end else if (cmd_i.clr_step && clr_node) begin
      head_we = 1'b1;
      head_wa = NW'(clr_q);
      head_wd = NIL;
    end
  end

  // Select slot port
  always_comb begin
    slot_we      = cmd_i.link_a || cmd_i.link_b;
    slot_wa      = SIW'(slot_cnt_q);
    slot_nbr_wd  = b_q;
    slot_next_wd = head_rd;
    if (cmd_i.link_b) begin
      slot_wa     = SIW'(slot_cnt_q + LW'(1));
      slot_nbr_wd = a_q;
      // a self loop links behind the slot just written
      if (a_q == b_q) slot_next_wd = slot_cnt_q;
    end
    slot_re = cmd_i.link_ld || cmd_i.vis_chk;
    slot_ra = cmd_i.link_ld ? SIW'(head_rd) : SIW'(s_q);
  end

  // Select flag and stack ports
  always_comb begin
    pres_we = cmd_i.link_a || cmd_i.link_b || (cmd_i.clr_step && clr_node);
    pres_wa = cmd_i.link_a ? a_q : (cmd_i.link_b ? b_q : NW'(clr_q));
    pres_wd = !cmd_i.clr_step;

    vis_re = cmd_i.scan_rd || cmd_i.nbr_take;
    vis_ra = cmd_i.scan_rd ? n_q : nbr_rd;
    vis_we = 1'b0;
    vis_wa = n_q;
    vis_wd = 1'b1;
    stk_we = 1'b0;
    stk_wa = '0;
    stk_wd = n_q;
    if (cmd_i.comp_start) begin
      vis_we = 1'b1;
      stk_we = 1'b1;
    end else if (cmd_i.vis_chk && !visited_rd) begin
      vis_we = 1'b1;
      vis_wa = nb_q;
      stk_we = 1'b1;
      stk_wa = NW'(depth_q);
      stk_wd = nb_q;
    end else if (cmd_i.clr_step && clr_node) begin
      vis_we = 1'b1;
      vis_wa = NW'(clr_q);
      vis_wd = 1'b0;
    end

    rep_we = (cmd_i.size_take && size_new) || cmd_i.clr_step;
    rep_wa = cmd_i.clr_step ? clr_q : count_q;
    rep_wd = !cmd_i.clr_step;
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      next_mem[slot_wa] <= slot_next_wd;
      nbr_mem[slot_wa]  <= slot_nbr_wd;
    end
    if (slot_re) begin
      next_rd <= next_mem[slot_ra];
      nbr_rd  <= nbr_mem[slot_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pres_we) present_mem[pres_wa] <= pres_wd;
    if (cmd_i.scan_rd) present_rd <= present_mem[n_q];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) visited_mem[vis_wa] <= vis_wd;
    if (vis_re) visited_rd <= visited_mem[vis_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    if (cmd_i.pop) stk_rd <= stack_mem[NW'(depth_q - DW'(1))];
  end

  always_ff @(posedge clk_i) begin
    if (rep_we) rep_mem[rep_wa] <= rep_wd;
    if (cmd_i.size_rd) rep_rd <= rep_mem[count_q];
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q   <= NW'(in_data_i.end_a);
      b_q   <= NW'(in_data_i.end_b);
      fin_q <= in_data_i.final_edge;
    end
    if (cmd_i.link_ld) s_q <= head_rd;
    else if (cmd_i.nbr_take) s_q <= next_rd;
    if (cmd_i.nbr_take) nb_q <= nbr_rd;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      depth_q     <= '0;
      count_q     <= '0;
      clr_q       <= '0;
      pend_q      <= '0;
      pend_v_q    <= 1'b0;
      res_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cmd_i.load && !in_ok) ovf_q <= 1'b1;
      if (cmd_i.link_b) slot_cnt_q <= slot_cnt_q + LW'(2);
      if (cmd_i.scan_next) n_q <= n_q + NW'(1);

      // Walk stack and component count
      if (cmd_i.comp_start) begin
        depth_q <= DW'(1);
        count_q <= DW'(1);
      end else if (cmd_i.pop) begin
        depth_q <= depth_q - DW'(1);
      end else if (cmd_i.vis_chk && !visited_rd) begin
        depth_q <= depth_q + DW'(1);
        count_q <= count_q + DW'(1);
      end

      // Present a new result word, or drop the current one once taken
      if ((cmd_i.size_take && size_new && take_ok && pend_v_q) || cmd_i.flush) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // Keep one size back so the last word can be flagged
      if (cmd_i.size_take && size_new && take_ok) begin
        if (pend_v_q) begin
          out_q.comp_size     <= 11'(pend_q);
          out_q.last_size     <= 1'b0;
          out_q.edges_dropped <= ovf_q;
        end
        pend_q    <= count_q;
        pend_v_q  <= 1'b1;
        res_cnt_q <= res_cnt_q + RES_CNT_W'(1);
      end

      if (cmd_i.flush) begin
        out_q.comp_size     <= pend_v_q ? 11'(pend_q) : 11'd0;
        out_q.last_size     <= 1'b1;
        out_q.edges_dropped <= ovf_q;
        clr_q               <= '0;
      end

      // Clearing sweep, then reset the graph counters
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + DW'(1);
        if (clr_q == DW'(NODE_COUNT)) begin
          slot_cnt_q <= '0;
          ovf_q      <= 1'b0;
          n_q        <= '0;
          pend_v_q   <= 1'b0;
          res_cnt_q  <= '0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/component_size_finder.sv]
`timescale 1ns / 1ps
// Connected component sizes of an undirected graph. Edges arrive one word
// at a time; each accepted edge is taken as a word and then written into
// its two adjacency slots one after the other, and an edge that is dropped
// for range or capacity is only taken and flagged through edges_dropped.
// The word flagged final_edge starts a depth-first walk that scans the
// nodes, pops nodes off the walk stack and follows their adjacency slots,
// each memory having one read port; a result word still waiting to be
// taken holds the walk. Up to RESULT_LIMIT distinct sizes above one are
// sent, each once in discovery order, or a single size 0 if none; the last
// word carries last_size. After reset and after every graph a sweep
// clears the node stores, during which no edge is taken.
module component_size_finder
  import csf_pkg::*;
#(
  parameter int unsigned NODE_COUNT    = 1024,
  parameter int unsigned EDGE_CAPACITY = 2048
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  csf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output csf_out_t out_data_o
);

  csf_cmd_t  cmd;
  csf_stat_t stat;

  csf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  csf_dp #(
    .NODE_COUNT    (NODE_COUNT),
    .EDGE_CAPACITY (EDGE_CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  // The closing word of a graph follows the flush
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |=> out_valid_o && out_data_o.last_size)
    else $error("flush did not present the closing word");

  // No size is held back while edges are taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat.pend_v)
    else $error("pending size left over into edge loading");

  // Size zero only ever stands alone as the last word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.comp_size == 11'd0) |-> out_data_o.last_size)
    else $error("size zero sent before the end of the graph");

endmodule
